// File: hdl/sic_pkg.sv
// Package for the segment intersection clip block: widths, payload structs and
// saturation helpers. No dependencies; every other file imports it.
`default_nettype none
package sic_pkg;

    // Fixed-point format of all coordinates and slopes.
    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;
    // Width of the divider numerator magnitude and of the raw quotient.
    localparam int NW        = DW + FRAC_BITS;

    localparam logic signed [DW-1:0] VERT_MARK = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] SAT_MAX   = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] SAT_MIN   = {1'b1, {(DW-1){1'b0}}};

    typedef struct packed {
        logic signed [DW-1:0] first_slope;
        logic signed [DW-1:0] first_intercept;
        logic signed [DW-1:0] first_start_x;
        logic signed [DW-1:0] first_start_y;
        logic signed [DW-1:0] first_end_x;
        logic signed [DW-1:0] first_end_y;
        logic signed [DW-1:0] second_slope;
        logic signed [DW-1:0] second_intercept;
        logic signed [DW-1:0] second_start_x;
        logic signed [DW-1:0] second_start_y;
        logic signed [DW-1:0] second_end_x;
        logic signed [DW-1:0] second_end_y;
    } t_seg_in;

    typedef struct packed {
        logic                 hit;
        logic signed [DW-1:0] clipped_end_x;
        logic signed [DW-1:0] clipped_end_y;
    } t_seg_out;

    // Case flags that travel with each item down the pipeline.
    typedef struct packed {
        logic par;   // equal slopes, never a hit
        logic vert;  // at least one line is vertical
        logic v2;    // the second line is the vertical one
        logic neg;   // quotient sign
    } t_ctl;

    // Saturate a 33-bit signed sum to 32 bits.
    function automatic logic signed [DW-1:0] sat_sum(input logic signed [DW:0] v);
        logic signed [DW-1:0] r;
        if (v[DW] != v[DW-1]) begin
            r = v[DW] ? SAT_MIN : SAT_MAX;
        end else begin
            r = v[DW-1:0];
        end
        return r;
    endfunction

    // Saturate a 64-bit signed value to 32 bits.
    function automatic logic signed [DW-1:0] sat_wide(input logic signed [2*DW-1:0] v);
        logic signed [DW-1:0] r;
        if (!v[2*DW-1] && (|v[2*DW-2:DW-1])) begin
            r = SAT_MAX;
        end else if (v[2*DW-1] && !(&v[2*DW-2:DW-1])) begin
            r = SAT_MIN;
        end else begin
            r = v[DW-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hdl/sic_if.sv
// Valid/ready channel interfaces for the segment intersection clip block.
// Depends on sic_pkg for the payload structs.
`default_nettype none
interface sic_in_if;
    import sic_pkg::*;
    logic    valid;
    logic    ready;
    t_seg_in data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sic_out_if;
    import sic_pkg::*;
    logic     valid;
    logic     ready;
    t_seg_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/segment_intersection_clip_top.sv
// Pipeline: input register, divider stages, select, multiply, scale, intercept, output.
// Throughput: one beat per cycle unless stalled; the divider retires one quotient bit
// per stage. The whole pipeline advances whenever the output register is empty or taken.
// Reset (synchronous, active low) clears all valid bits; payload is not reset.
// Uses sic_pkg and the channel interfaces in sic_if.sv.
`default_nettype none
module segment_intersection_clip_top (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sic_in_if.sink      i_in,
    sic_out_if.source   o_out
);
    import sic_pkg::*;

    logic en;
    assign en = !o_out.valid || o_out.ready;
    assign i_in.ready = en;

    // Stage 0: register the beat, form differences and divider magnitudes.
    logic              r_pre_v;
    t_seg_in           r_pre_d;
    t_ctl              r_pre_ctl;
    logic [DW-1:0]     r_pre_den;
    logic [NW-1:0]     r_pre_num;
    logic signed [DW:0] n_den, n_numd;
    logic [DW:0]       n_denm, n_numm;
    t_ctl              n_ctl;

    always_comb begin
        n_den  = {i_in.data.first_slope[DW-1], i_in.data.first_slope}
               - {i_in.data.second_slope[DW-1], i_in.data.second_slope};
        n_numd = {i_in.data.second_intercept[DW-1], i_in.data.second_intercept}
               - {i_in.data.first_intercept[DW-1], i_in.data.first_intercept};
        n_denm = n_den[DW] ? -n_den : n_den;
        n_numm = n_numd[DW] ? -n_numd : n_numd;
        n_ctl.par  = (i_in.data.first_slope == i_in.data.second_slope);
        n_ctl.v2   = (i_in.data.second_slope == VERT_MARK);
        n_ctl.vert = (i_in.data.first_slope == VERT_MARK) || n_ctl.v2;
        n_ctl.neg  = n_den[DW] ^ n_numd[DW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_v <= 1'b0;
        end else if (en) begin
            r_pre_v <= i_in.valid;
        end
        if (en) begin
            r_pre_d   <= i_in.data;
            r_pre_ctl <= n_ctl;
            r_pre_den <= n_denm[DW-1:0];
            r_pre_num <= {n_numm[DW-1:0], {FRAC_BITS{1'b0}}};
        end
    end

    // Divider: one restoring step per stage; quotient bits shift in as
    // numerator bits shift out.
    logic          r_dv_v   [NW];
    t_seg_in       r_dv_d   [NW];
    t_ctl          r_dv_ctl [NW];
    logic [DW-1:0] r_dv_den [NW];
    logic [DW-1:0] r_dv_rem [NW];
    logic [NW-1:0] r_dv_nq  [NW];

    for (genvar k = 0; k < NW; k++) begin : g_div
        logic          p_v;
        t_seg_in       p_d;
        t_ctl          p_ctl;
        logic [DW-1:0] p_den, p_rem;
        logic [NW-1:0] p_nq;
        logic [DW:0]   trial, diff;
        logic          ge;

        if (k == 0) begin : g_first
            assign p_v   = r_pre_v;
            assign p_d   = r_pre_d;
            assign p_ctl = r_pre_ctl;
            assign p_den = r_pre_den;
            assign p_rem = '0;
            assign p_nq  = r_pre_num;
        end else begin : g_next
            assign p_v   = r_dv_v[k-1];
            assign p_d   = r_dv_d[k-1];
            assign p_ctl = r_dv_ctl[k-1];
            assign p_den = r_dv_den[k-1];
            assign p_rem = r_dv_rem[k-1];
            assign p_nq  = r_dv_nq[k-1];
        end

        always_comb begin
            trial = {p_rem, p_nq[NW-1]};
            diff  = trial - {1'b0, p_den};
            ge    = (trial >= {1'b0, p_den});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k] <= 1'b0;
            end else if (en) begin
                r_dv_v[k] <= p_v;
            end
            if (en) begin
                r_dv_d[k]   <= p_d;
                r_dv_ctl[k] <= p_ctl;
                r_dv_den[k] <= p_den;
                r_dv_rem[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
                r_dv_nq[k]  <= {p_nq[NW-2:0], ge};
            end
        end
    end

    // Select stage: sign and saturate the quotient, pick x and the line for y.
    logic                 r_s_v;
    t_seg_in              r_s_d;
    t_ctl                 r_s_ctl;
    logic signed [DW-1:0] r_s_x, r_s_a, r_s_b;
    logic [NW-1:0]        qmag;
    logic signed [DW-1:0] n_xq, n_x, n_a, n_b;
    t_seg_in              dq;
    t_ctl                 cq;

    always_comb begin
        qmag = r_dv_nq[NW-1];
        dq   = r_dv_d[NW-1];
        cq   = r_dv_ctl[NW-1];
        if (!cq.neg) begin
            n_xq = (|qmag[NW-1:DW-1]) ? SAT_MAX : {1'b0, qmag[DW-2:0]};
        end else if ((|qmag[NW-1:DW]) || (qmag[DW-1] && (|qmag[DW-2:0]))) begin
            n_xq = SAT_MIN;
        end else begin
            n_xq = -qmag[DW-1:0];
        end
        if (cq.vert) begin
            n_x = cq.v2 ? dq.second_start_x : dq.first_start_x;
        end else begin
            n_x = n_xq;
        end
        if (cq.vert && !cq.v2) begin
            n_a = dq.second_slope;
            n_b = dq.second_intercept;
        end else begin
            n_a = dq.first_slope;
            n_b = dq.first_intercept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_v <= 1'b0;
        end else if (en) begin
            r_s_v <= r_dv_v[NW-1];
        end
        if (en) begin
            r_s_d   <= dq;
            r_s_ctl <= cq;
            r_s_x   <= n_x;
            r_s_a   <= n_a;
            r_s_b   <= n_b;
        end
    end

    // Multiply stage: full 64-bit product of slope and x.
    logic                   r_m_v;
    t_seg_in                r_m_d;
    t_ctl                   r_m_ctl;
    logic signed [DW-1:0]   r_m_x, r_m_b;
    logic signed [2*DW-1:0] r_m_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else if (en) begin
            r_m_v <= r_s_v;
        end
        if (en) begin
            r_m_d   <= r_s_d;
            r_m_ctl <= r_s_ctl;
            r_m_x   <= r_s_x;
            r_m_b   <= r_s_b;
            r_m_p   <= r_s_a * r_s_x;
        end
    end

    // Scale stage: floor shift by the fraction bits, then saturate.
    logic                 r_q_v;
    t_seg_in              r_q_d;
    t_ctl                 r_q_ctl;
    logic signed [DW-1:0] r_q_x, r_q_b, r_q_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_v <= 1'b0;
        end else if (en) begin
            r_q_v <= r_m_v;
        end
        if (en) begin
            r_q_d   <= r_m_d;
            r_q_ctl <= r_m_ctl;
            r_q_x   <= r_m_x;
            r_q_b   <= r_m_b;
            r_q_p   <= sat_wide(r_m_p >>> FRAC_BITS);
        end
    end

    // Intercept stage: add b and saturate to get y.
    logic                 r_y_v;
    t_seg_in              r_y_d;
    t_ctl                 r_y_ctl;
    logic signed [DW-1:0] r_y_x, r_y_y;
    logic signed [DW:0]   n_ysum;

    assign n_ysum = {r_q_p[DW-1], r_q_p} + {r_q_b[DW-1], r_q_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y_v <= 1'b0;
        end else if (en) begin
            r_y_v <= r_q_v;
        end
        if (en) begin
            r_y_d   <= r_q_d;
            r_y_ctl <= r_q_ctl;
            r_y_x   <= r_q_x;
            r_y_y   <= sat_sum(n_ysum);
        end
    end

    // Bounds stage: inclusive range checks and the output register.
    logic     r_o_v;
    t_seg_out r_o_d;
    logic     in1x, in2x, in1y, in2y, n_hit;

    always_comb begin
        in1x = (r_y_x >= ((r_y_d.first_start_x < r_y_d.first_end_x) ?
                          r_y_d.first_start_x : r_y_d.first_end_x))
            && (r_y_x <= ((r_y_d.first_start_x < r_y_d.first_end_x) ?
                          r_y_d.first_end_x : r_y_d.first_start_x));
        in2x = (r_y_x >= ((r_y_d.second_start_x < r_y_d.second_end_x) ?
                          r_y_d.second_start_x : r_y_d.second_end_x))
            && (r_y_x <= ((r_y_d.second_start_x < r_y_d.second_end_x) ?
                          r_y_d.second_end_x : r_y_d.second_start_x));
        in1y = (r_y_y >= ((r_y_d.first_start_y < r_y_d.first_end_y) ?
                          r_y_d.first_start_y : r_y_d.first_end_y))
            && (r_y_y <= ((r_y_d.first_start_y < r_y_d.first_end_y) ?
                          r_y_d.first_end_y : r_y_d.first_start_y));
        in2y = (r_y_y >= ((r_y_d.second_start_y < r_y_d.second_end_y) ?
                          r_y_d.second_start_y : r_y_d.second_end_y))
            && (r_y_y <= ((r_y_d.second_start_y < r_y_d.second_end_y) ?
                          r_y_d.second_end_y : r_y_d.second_start_y));
        n_hit = !r_y_ctl.par && in1x && in2x && (!r_y_ctl.vert || (in1y && in2y));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (en) begin
            r_o_v <= r_y_v;
        end
        if (en) begin
            r_o_d.hit           <= n_hit;
            r_o_d.clipped_end_x <= n_hit ? r_y_x : r_y_d.second_end_x;
            r_o_d.clipped_end_y <= n_hit ? r_y_y : r_y_d.second_end_y;
        end
    end

    assign o_out.valid = r_o_v;
    assign o_out.data  = r_o_d;

    // Checks on the pipeline control.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_pre_v && !r_s_v && !r_o_v)
        else $error("valid bits not cleared by reset");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_s_v) && $stable(r_y_v) && $stable(r_dv_v[NW-1]))
        else $error("pipeline moved during a stall");
    a_div_to_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_dv_v[NW-1] |=> r_s_v)
        else $error("divider beat lost");
    a_parallel_nohit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_y_v && r_y_ctl.par |=> r_o_v && !r_o_d.hit)
        else $error("parallel lines reported a hit");

endmodule
`default_nettype wire
